// ===== src/mml_note_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the note sequencer.
// Shared concurrent assertion forms, clocked on clk with reset disable.
// ----------------------------------------------------------------------------
`ifndef MML_NOTE_SEQUENCER_MACROS_SVH
`define MML_NOTE_SEQUENCER_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define MML_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Asserts that an antecedent implies a consequent in the next cycle.
`define MML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mml_pkg.sv =====
// ----------------------------------------------------------------------------
// MML sequencer package
// Shared types, constants and the note frequency table.
// ----------------------------------------------------------------------------
package mml_pkg;

  localparam int MAX_DOTS_DEF = 3;

  localparam logic [1:0] KIND_TONE = 2'd0;
  localparam logic [1:0] KIND_GAP  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [11:0] frequency_hz;
    logic [15:0] duration_ms;
    logic [6:0]  volume_level;
    logic        last_event;
  } evt_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       track_start;
  } chr_t;

  // Division request and response between the parser and the divider.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

  function automatic logic [11:0] note_freq(input logic [6:0] idx);
    logic [11:0] f;
    case (idx)
      7'd1: f = 12'd16;    7'd2: f = 12'd17;    7'd3: f = 12'd18;
      7'd4: f = 12'd19;    7'd5: f = 12'd20;    7'd6: f = 12'd21;
      7'd7: f = 12'd23;    7'd8: f = 12'd24;    7'd9: f = 12'd25;
      7'd10: f = 12'd27;   7'd11: f = 12'd29;   7'd12: f = 12'd30;
      7'd13: f = 12'd32;   7'd14: f = 12'd34;   7'd15: f = 12'd36;
      7'd16: f = 12'd38;   7'd17: f = 12'd41;   7'd18: f = 12'd43;
      7'd19: f = 12'd46;   7'd20: f = 12'd49;   7'd21: f = 12'd51;
      7'd22: f = 12'd55;   7'd23: f = 12'd58;   7'd24: f = 12'd61;
      7'd25: f = 12'd65;   7'd26: f = 12'd69;   7'd27: f = 12'd73;
      7'd28: f = 12'd77;   7'd29: f = 12'd82;   7'd30: f = 12'd87;
      7'd31: f = 12'd92;   7'd32: f = 12'd98;   7'd33: f = 12'd103;
      7'd34: f = 12'd110;  7'd35: f = 12'd116;  7'd36: f = 12'd123;
      7'd37: f = 12'd130;  7'd38: f = 12'd138;  7'd39: f = 12'd146;
      7'd40: f = 12'd155;  7'd41: f = 12'd164;  7'd42: f = 12'd174;
      7'd43: f = 12'd185;  7'd44: f = 12'd196;  7'd45: f = 12'd207;
      7'd46: f = 12'd220;  7'd47: f = 12'd233;  7'd48: f = 12'd246;
      7'd49: f = 12'd261;  7'd50: f = 12'd277;  7'd51: f = 12'd293;
      7'd52: f = 12'd311;  7'd53: f = 12'd329;  7'd54: f = 12'd349;
      7'd55: f = 12'd370;  7'd56: f = 12'd392;  7'd57: f = 12'd415;
      7'd58: f = 12'd440;  7'd59: f = 12'd466;  7'd60: f = 12'd493;
      7'd61: f = 12'd523;  7'd62: f = 12'd554;  7'd63: f = 12'd587;
      7'd64: f = 12'd622;  7'd65: f = 12'd659;  7'd66: f = 12'd698;
      7'd67: f = 12'd739;  7'd68: f = 12'd783;  7'd69: f = 12'd830;
      7'd70: f = 12'd880;  7'd71: f = 12'd932;  7'd72: f = 12'd987;
      7'd73: f = 12'd1046; 7'd74: f = 12'd1108; 7'd75: f = 12'd1174;
      7'd76: f = 12'd1244; 7'd77: f = 12'd1318; 7'd78: f = 12'd1396;
      7'd79: f = 12'd1479; 7'd80: f = 12'd1567; 7'd81: f = 12'd1661;
      7'd82: f = 12'd1760; 7'd83: f = 12'd1864; 7'd84: f = 12'd1975;
      7'd85: f = 12'd2093; 7'd86: f = 12'd2217; 7'd87: f = 12'd2349;
      7'd88: f = 12'd2489; 7'd89: f = 12'd2637; 7'd90: f = 12'd2793;
      7'd91: f = 12'd2959; 7'd92: f = 12'd3135; 7'd93: f = 12'd3322;
      7'd94: f = 12'd3520; 7'd95: f = 12'd3729; 7'd96: f = 12'd3951;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== src/mml_if.sv =====
// ----------------------------------------------------------------------------
// MML stream interface
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface mml_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/mml_div.sv =====
// ----------------------------------------------------------------------------
// MML serial divider
// Restoring divider, one quotient bit per cycle, saturating at 65535.
// ----------------------------------------------------------------------------
module mml_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mml_pkg::div_req_t req,
  output mml_pkg::div_rsp_t rsp
);
  import mml_pkg::*;

  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, quo_r[31]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.num;
      den_nxt = req.den;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo = (quo_r[31:16] != 16'd0) ? 16'hFFFF : quo_r[15:0];
endmodule

// ===== src/mml_parse.sv =====
// ----------------------------------------------------------------------------
// MML parser and sequencer
// Character parse, settings, and event generation around the divider.
// ----------------------------------------------------------------------------
module mml_parse #(
  parameter int MAX_DOTS = mml_pkg::MAX_DOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mml_if.sink               chin,
  mml_if.source             evout,
  output mml_pkg::div_req_t dreq,
  input  mml_pkg::div_rsp_t drsp
);
  import mml_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001, PH_MWAIT = 7'b0000010, PH_VALUE = 7'b0000100,
    PH_NSTART = 7'b0001000, PH_NACC = 7'b0010000, PH_NDOTS = 7'b0100000,
    PH_NLEN = 7'b1000000
  } phase_t;

  typedef enum logic [7:0] {
    S_WAIT = 8'b00000001, S_PARSE = 8'b00000010, S_DEN = 8'b00000100,
    S_DON = 8'b00001000, S_DOFF = 8'b00010000, S_OUT1 = 8'b00100000,
    S_OUT2 = 8'b01000000, S_OUT3 = 8'b10000000
  } seq_t;

  localparam int DW = $clog2(MAX_DOTS + 1);

  seq_t   seq_r, seq_nxt;
  phase_t ph_r, ph_nxt;
  logic [6:0] note_r, note_nxt, dlen_r, dlen_nxt, vol_r, vol_nxt;
  logic       flat_r, flat_nxt, play_r, play_nxt, vdig_r, vdig_nxt;
  logic [DW-1:0] dots_r, dots_nxt, fdots_r, fdots_nxt;
  logic [9:0] acc_r, acc_nxt;
  logic [2:0] oct_r, oct_nxt;
  logic [7:0] tempo_r, tempo_nxt, vcmd_r, vcmd_nxt, ch_r, ch_nxt;
  logic [1:0] art_r, art_nxt;
  logic       fin_r, fin_nxt, endt_r, endt_nxt, again_nxt;
  logic [6:0] len_r, len_nxt;
  logic [31:0] den_r, den_nxt;
  logic [15:0] on_r, on_nxt, off_r, off_nxt;
  logic [6:0] fnote_r, fnote_nxt, fvol_r, fvol_nxt;
  evt_t  ev_r, ev_nxt;
  logic  ov_r, ov_nxt;
  div_req_t dreq_nxt;

  logic [7:0] ch;
  logic       digit;
  logic [13:0] acc10;
  logic [9:0]  accd;
  logic [3:0]  artn;
  logic [31:0] kfac;
  logic [6:0]  lenv;
  logic        is_c;

  always_comb begin
    ch = (ch_r >= 8'h41 && ch_r <= 8'h5A) ? ch_r + 8'd32 : ch_r;
    digit = ch >= 8'h30 && ch <= 8'h39;
    acc10 = {acc_r, 3'b0} + {3'b0, acc_r, 1'b0} + {10'd0, ch[3:0]};
    accd = (acc10 > 14'd1023) ? 10'd1023 : acc10[9:0];
    artn = (art_r == 2'd1) ? 4'd8 : ((art_r == 2'd2) ? 4'd6 : 4'd7);
    kfac = (32'd240000 << (fdots_r + 1)) - 32'd240000;
    lenv = (acc_r == 10'd0) ? 7'd1 : ((acc_r > 10'd64) ? 7'd64 : acc_r[6:0]);
    is_c = (note_r == 7'd1) || (note_r == 7'd13) || (note_r == 7'd25) ||
           (note_r == 7'd37) || (note_r == 7'd49) || (note_r == 7'd61) ||
           (note_r == 7'd73) || (note_r == 7'd85);
  end

  always_comb begin
    seq_nxt = seq_r; ph_nxt = ph_r; note_nxt = note_r; dlen_nxt = dlen_r;
    vol_nxt = vol_r; flat_nxt = flat_r; play_nxt = play_r; vdig_nxt = vdig_r;
    dots_nxt = dots_r; acc_nxt = acc_r; oct_nxt = oct_r; tempo_nxt = tempo_r;
    vcmd_nxt = vcmd_r; ch_nxt = ch_r; art_nxt = art_r; fin_nxt = fin_r;
    endt_nxt = endt_r; again_nxt = 1'b0; len_nxt = len_r; den_nxt = den_r;
    on_nxt = on_r; off_nxt = off_r; fnote_nxt = fnote_r; fvol_nxt = fvol_r;
    fdots_nxt = fdots_r;
    ev_nxt = ev_r; ov_nxt = ov_r;
    dreq_nxt = '0;
    case (seq_r)
      S_WAIT: begin
        if (chin.valid && !ov_r) begin
          ch_nxt = chin.data.char_code;
          fin_nxt = 1'b0;
          endt_nxt = 1'b0;
          seq_nxt = S_PARSE;
          if (chin.data.track_start) begin
            ph_nxt = PH_IDLE; note_nxt = '0; flat_nxt = 1'b0; dots_nxt = '0;
            acc_nxt = '0; oct_nxt = 3'd4; dlen_nxt = 7'd4; tempo_nxt = 8'd120;
            vol_nxt = 7'd127; art_nxt = 2'd0; vcmd_nxt = '0; vdig_nxt = 1'b0;
            play_nxt = 1'b1;
          end else if (!play_r) begin
            seq_nxt = S_WAIT;
          end
        end
      end
      S_PARSE: begin
        seq_nxt = S_DEN;
        case (ph_r)
          PH_IDLE: begin
            case (ch)
              8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67: begin
                case (ch)
                  8'h61: note_nxt = 7'd10 + {oct_r, 3'b0} + {1'b0, oct_r, 2'b0};
                  8'h62: note_nxt = 7'd12 + {oct_r, 3'b0} + {1'b0, oct_r, 2'b0};
                  8'h63: note_nxt = 7'd1 + {oct_r, 3'b0} + {1'b0, oct_r, 2'b0};
                  8'h64: note_nxt = 7'd3 + {oct_r, 3'b0} + {1'b0, oct_r, 2'b0};
                  8'h65: note_nxt = 7'd5 + {oct_r, 3'b0} + {1'b0, oct_r, 2'b0};
                  8'h66: note_nxt = 7'd6 + {oct_r, 3'b0} + {1'b0, oct_r, 2'b0};
                  default: note_nxt = 7'd8 + {oct_r, 3'b0} + {1'b0, oct_r, 2'b0};
                endcase
                flat_nxt = 1'b0; dots_nxt = '0; acc_nxt = '0; ph_nxt = PH_NSTART;
              end
              8'h70, 8'h72: begin
                note_nxt = '0; flat_nxt = 1'b0; dots_nxt = '0; acc_nxt = '0;
                ph_nxt = PH_NSTART;
              end
              8'h6C, 8'h6F, 8'h74, 8'h76, 8'h6E: begin
                vcmd_nxt = ch; vdig_nxt = 1'b0; acc_nxt = '0; ph_nxt = PH_VALUE;
              end
              8'h6D: ph_nxt = PH_MWAIT;
              8'h3C: if (oct_r != 3'd0) oct_nxt = oct_r - 3'd1;
              8'h3E: if (oct_r != 3'd7) oct_nxt = oct_r + 3'd1;
              8'h00, 8'h2C: begin
                endt_nxt = 1'b1; play_nxt = 1'b0; ph_nxt = PH_IDLE;
              end
              default: ;
            endcase
          end
          PH_MWAIT: begin
            ph_nxt = PH_IDLE;
            if (ch == 8'h6E) art_nxt = 2'd0;
            else if (ch == 8'h6C) art_nxt = 2'd1;
            else if (ch == 8'h73) art_nxt = 2'd2;
            else if (ch == 8'h00 || ch == 8'h2C) begin
              endt_nxt = 1'b1; play_nxt = 1'b0;
            end
          end
          PH_VALUE: begin
            if (digit) begin
              acc_nxt = accd; vdig_nxt = 1'b1;
            end else begin
              ph_nxt = PH_IDLE;
              again_nxt = 1'b1;
              seq_nxt = S_PARSE;
              if (vdig_r) begin
                case (vcmd_r)
                  8'h6C: dlen_nxt = lenv;
                  8'h6F: oct_nxt = (acc_r > 10'd7) ? 3'd7 : acc_r[2:0];
                  8'h74: tempo_nxt = (acc_r < 10'd32) ? 8'd32 :
                                     ((acc_r > 10'd255) ? 8'd255 : acc_r[7:0]);
                  8'h76: vol_nxt = (acc_r > 10'd127) ? 7'd127 : acc_r[6:0];
                  default: begin
                    note_nxt = (acc_r > 10'd96) ? 7'd96 : acc_r[6:0];
                    flat_nxt = 1'b0; dots_nxt = '0; acc_nxt = '0;
                    ph_nxt = PH_NSTART;
                  end
                endcase
              end
            end
          end
          PH_NSTART, PH_NACC, PH_NDOTS, PH_NLEN: begin
            if (ph_r == PH_NSTART && (ch == 8'h2B || ch == 8'h23)) begin
              if (note_r != 7'd0 && note_r < 7'd96) note_nxt = note_r + 7'd1;
              ph_nxt = PH_NACC;
            end else if (ph_r == PH_NSTART && ch == 8'h2D) begin
              if (note_r != 7'd0) begin
                if (is_c) flat_nxt = 1'b1;
                note_nxt = note_r - 7'd1;
              end
              ph_nxt = PH_NACC;
            end else if (ph_r == PH_NSTART && ch == 8'h2E) begin
              dots_nxt = DW'(1); ph_nxt = PH_NDOTS;
            end else if (ph_r == PH_NDOTS && ch == 8'h2E) begin
              if (dots_r < DW'(MAX_DOTS)) dots_nxt = dots_r + DW'(1);
            end else if (digit) begin
              acc_nxt = accd; ph_nxt = PH_NLEN;
            end else begin
              fin_nxt = 1'b1;
              len_nxt = (ph_r == PH_NLEN) ? lenv : dlen_r;
              fnote_nxt = note_r;
              fvol_nxt = vol_r;
              fdots_nxt = dots_r;
              ph_nxt = PH_IDLE;
              again_nxt = 1'b1;
              seq_nxt = S_PARSE;
            end
          end
          default: ph_nxt = PH_IDLE;
        endcase
        if (!again_nxt && !fin_r && !endt_nxt) seq_nxt = S_WAIT;
        else if (!again_nxt && fin_r) seq_nxt = S_DEN;
        else if (!again_nxt) seq_nxt = S_OUT3;
      end
      S_DEN: begin
        den_nxt = ({25'd0, len_r} * {24'd0, tempo_r}) << (fdots_r + 3);
        seq_nxt = S_DON;
        dreq_nxt.start = 1'b1;
        dreq_nxt.num = kfac * {28'd0, artn};
        dreq_nxt.den = ({25'd0, len_r} * {24'd0, tempo_r}) << (fdots_r + 3);
      end
      S_DON: begin
        if (drsp.done) begin
          on_nxt = drsp.quo;
          dreq_nxt.start = 1'b1;
          dreq_nxt.num = kfac * {28'd0, 4'd8 - artn};
          dreq_nxt.den = den_r;
          seq_nxt = S_DOFF;
        end
      end
      S_DOFF: begin
        if (drsp.done) begin
          off_nxt = drsp.quo;
          seq_nxt = S_OUT1;
        end
      end
      S_OUT1: begin
        if (!ov_r) begin
          ev_nxt = '{KIND_TONE, note_freq(fnote_r), on_r, fvol_r,
                     (off_r == 16'd0) && !endt_r};
          ov_nxt = 1'b1;
          seq_nxt = (off_r != 16'd0) ? S_OUT2 : (endt_r ? S_OUT3 : S_WAIT);
        end
      end
      S_OUT2: begin
        if (!ov_r) begin
          ev_nxt = '{KIND_GAP, 12'd0, off_r, 7'd0, !endt_r};
          ov_nxt = 1'b1;
          seq_nxt = endt_r ? S_OUT3 : S_WAIT;
        end
      end
      S_OUT3: begin
        if (!ov_r) begin
          ev_nxt = '{KIND_END, 12'd0, 16'd0, 7'd0, 1'b1};
          ov_nxt = 1'b1;
          seq_nxt = S_WAIT;
        end
      end
      default: seq_nxt = S_WAIT;
    endcase
    if (ov_r && evout.ready) ov_nxt = 1'b0;
    if ((seq_r == S_OUT1 || seq_r == S_OUT2 || seq_r == S_OUT3) && !ov_r) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= S_WAIT; ph_r <= PH_IDLE; note_r <= '0; flat_r <= 1'b0; dots_r <= '0;
      acc_r <= '0; oct_r <= 3'd4; dlen_r <= 7'd4; tempo_r <= 8'd120;
      vol_r <= 7'd127; art_r <= 2'd0; play_r <= 1'b0; vcmd_r <= '0;
      vdig_r <= 1'b0; fin_r <= 1'b0; endt_r <= 1'b0; ov_r <= 1'b0;
      dreq <= '0;
    end else begin
      seq_r <= seq_nxt; ph_r <= ph_nxt; note_r <= note_nxt; flat_r <= flat_nxt;
      dots_r <= dots_nxt; acc_r <= acc_nxt; oct_r <= oct_nxt; dlen_r <= dlen_nxt;
      tempo_r <= tempo_nxt; vol_r <= vol_nxt; art_r <= art_nxt;
      play_r <= play_nxt; vcmd_r <= vcmd_nxt; vdig_r <= vdig_nxt;
      fin_r <= fin_nxt; endt_r <= endt_nxt; ov_r <= ov_nxt;
      dreq <= dreq_nxt;
    end
    ch_r <= ch_nxt; len_r <= len_nxt; den_r <= den_nxt; on_r <= on_nxt;
    off_r <= off_nxt; fnote_r <= fnote_nxt; fvol_r <= fvol_nxt; ev_r <= ev_nxt;
    fdots_r <= fdots_nxt;
  end

  assign chin.ready = (seq_r == S_WAIT) && !ov_r;
  assign evout.valid = ov_r;
  assign evout.data = ev_r;
endmodule

// ===== src/mml_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// MML note sequencer
// Plays one track of MML text, one character word in, up to three events out.
// ----------------------------------------------------------------------------
// Channel   Dir  Word
// in_       in   char_code, track_start
// out_      out  event_kind, frequency_hz, duration_ms, volume_level, last_event
//
// A character that ends a value is parsed a second time.
// A completed note adds two serial divisions.
// Each event waits in the output register until taken; input stalls meanwhile.
// Synchronous active-low reset restores the default settings, not playing.
// ----------------------------------------------------------------------------
`include "mml_note_sequencer_macros.svh"

module mml_note_sequencer #(
  parameter int MAX_DOTS = mml_pkg::MAX_DOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [11:0] out_frequency_hz,
  output logic [15:0] out_duration_ms,
  output logic [6:0]  out_volume_level,
  output logic        out_last_event
);
  import mml_pkg::*;

  mml_if #(.T(chr_t)) chin ();
  mml_if #(.T(evt_t)) evout ();
  div_req_t dreq;
  div_rsp_t drsp;

  assign chin.valid = in_valid;
  assign chin.data = '{in_char_code, in_track_start};
  assign in_ready = chin.ready;
  assign out_valid = evout.valid;
  assign evout.ready = out_ready;
  assign out_event_kind = evout.data.event_kind;
  assign out_frequency_hz = evout.data.frequency_hz;
  assign out_duration_ms = evout.data.duration_ms;
  assign out_volume_level = evout.data.volume_level;
  assign out_last_event = evout.data.last_event;

  mml_parse #(.MAX_DOTS(MAX_DOTS)) u_parse (
    .clk(clk), .rst_n(rst_n), .chin(chin), .evout(evout), .dreq(dreq), .drsp(drsp)
  );

  mml_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  `MML_ASSERT_IMPL(a_no_in_while_out, out_valid, !in_ready, "input taken with event pending")
  `MML_ASSERT_IMPL(a_end_last, out_valid && out_event_kind == KIND_END, out_last_event, "end not last")
  `MML_ASSERT_IMPL(a_gap_silent, out_valid && out_event_kind == KIND_GAP, out_frequency_hz == 12'd0, "gap has tone")
endmodule

// ===== test/mml_note_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// MML note sequencer testbench
// Sends MML text words through the valid/ready port, predicts every tone, gap
// and track-end event, and compares each event field by field.
// ----------------------------------------------------------------------------
module mml_note_sequencer_tb;
  import mml_pkg::*;

  localparam int PH_IDLE = 0, PH_MWAIT = 1, PH_VALUE = 2, PH_START = 3;
  localparam int PH_ACC = 4, PH_DOTS = 5, PH_LEN = 6;
  localparam int DOT_LIMIT = MAX_DOTS_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_char_code = 8'd0;
  logic in_track_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_event_kind;
  logic [11:0] out_frequency_hz;
  logic [15:0] out_duration_ms;
  logic [6:0] out_volume_level;
  logic out_last_event;

  mml_note_sequencer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_char_code(in_char_code), .in_track_start(in_track_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_kind(out_event_kind), .out_frequency_hz(out_frequency_hz),
    .out_duration_ms(out_duration_ms), .out_volume_level(out_volume_level),
    .out_last_event(out_last_event)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Musical state of the predicted sequencer.
  int phase, note_idx, dots, accum, octave, def_len, tempo, volume, artic;
  int cmd_char;
  bit playing, got_digits;

  evt_t expected_events[$];
  evt_t step_events[$];
  int errors = 0, words_sent = 0, events_seen = 0;
  bit quiet = 1'b0;

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int duration_of(int len, int eighths);
    longint num, den, q;
    num = 64'd240000 * ((2 << dots) - 1) * eighths;
    den = longint'(len) * tempo * (1 << dots) * 8;
    q = num / den;
    return q > 65535 ? 65535 : int'(q);
  endfunction

  task automatic push_event(logic [1:0] kind, int freq, int dur, int vol);
    evt_t e;
    e.event_kind = kind;
    e.frequency_hz = freq[11:0];
    e.duration_ms = dur[15:0];
    e.volume_level = vol[6:0];
    e.last_event = 1'b0;
    step_events.push_back(e);
  endtask

  task automatic complete_note();
    int len, a, on_ms, off_ms;
    len = phase == PH_LEN ? clampi(accum, 1, 64) : def_len;
    a = artic == 1 ? 8 : (artic == 2 ? 6 : 7);
    on_ms = duration_of(len, a);
    off_ms = duration_of(len, 8 - a);
    push_event(KIND_TONE, note_freq(7'(note_idx)), on_ms, volume);
    if (off_ms != 0) push_event(KIND_GAP, 0, off_ms, 0);
    phase = PH_IDLE;
  endtask

  task automatic end_of_track();
    push_event(KIND_END, 0, 0, 0);
    playing = 1'b0;
    phase = PH_IDLE;
  endtask

  task automatic begin_note(int idx);
    note_idx = idx > 96 ? 96 : idx;
    dots = 0;
    accum = 0;
    phase = PH_START;
  endtask

  function automatic void restore_defaults();
    phase = PH_IDLE; note_idx = 0; dots = 0; accum = 0; octave = 4;
    def_len = 4; tempo = 120; volume = 127; artic = 0; playing = 1'b0;
    cmd_char = 0; got_digits = 1'b0;
  endfunction

  task automatic add_digit(int c);
    accum = accum * 10 + (c - "0");
    if (accum > 1023) accum = 1023;
  endtask

  task automatic idle_char(int c);
    int semi;
    semi = -1;
    case (c)
      "a": semi = 10; "b": semi = 12; "c": semi = 1; "d": semi = 3;
      "e": semi = 5; "f": semi = 6; "g": semi = 8;
      "p", "r": begin_note(0);
      "l", "o", "t", "v", "n": begin
        cmd_char = c; got_digits = 1'b0; accum = 0; phase = PH_VALUE;
      end
      "m": phase = PH_MWAIT;
      "<": if (octave > 0) octave--;
      ">": if (octave < 7) octave++;
      0, ",": end_of_track();
      default: ;
    endcase
    if (semi >= 0) begin_note(semi + octave * 12);
  endtask

  task automatic predict_word(logic [7:0] code, logic start);
    int c;
    bit digit, done;
    c = code;
    if (c >= "A" && c <= "Z") c += 32;
    digit = c >= "0" && c <= "9";
    step_events.delete();
    if (start) begin
      restore_defaults();
      playing = 1'b1;
    end
    if (!playing) return;
    done = 1'b0;
    while (!done) begin
      case (phase)
        PH_IDLE: begin
          done = 1'b1;
          idle_char(c);
        end
        PH_MWAIT: begin
          done = 1'b1;
          phase = PH_IDLE;
          if (c == "n") artic = 0;
          else if (c == "l") artic = 1;
          else if (c == "s") artic = 2;
          else if (c == 0 || c == ",") end_of_track();
        end
        PH_VALUE: begin
          if (digit) begin
            add_digit(c); got_digits = 1'b1; done = 1'b1;
          end else begin
            phase = PH_IDLE;
            if (got_digits) begin
              if (cmd_char == "l") def_len = clampi(accum, 1, 64);
              else if (cmd_char == "o") octave = clampi(accum, 0, 7);
              else if (cmd_char == "t") tempo = clampi(accum, 32, 255);
              else if (cmd_char == "v") volume = clampi(accum, 0, 127);
              else begin_note(accum);
            end
          end
        end
        PH_START: begin
          if (c == "+" || c == "#") begin
            if (note_idx != 0 && note_idx < 96) note_idx++;
            phase = PH_ACC; done = 1'b1;
          end else if (c == "-") begin
            if (note_idx != 0) note_idx--;
            phase = PH_ACC; done = 1'b1;
          end else if (c == ".") begin
            dots = 1; phase = PH_DOTS; done = 1'b1;
          end else if (digit) begin
            add_digit(c); phase = PH_LEN; done = 1'b1;
          end else complete_note();
        end
        PH_DOTS: begin
          if (c == ".") begin
            if (dots < DOT_LIMIT) dots++;
            done = 1'b1;
          end else if (digit) begin
            add_digit(c); phase = PH_LEN; done = 1'b1;
          end else complete_note();
        end
        default: begin
          if (digit) begin
            add_digit(c); phase = PH_LEN; done = 1'b1;
          end else complete_note();
        end
      endcase
    end
    if (step_events.size() > 0) step_events[step_events.size()-1].last_event = 1'b1;
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endtask

  task automatic send_char(logic [7:0] code, logic start = 1'b0);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= code;
    in_track_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(code, start);
    words_sent++;
  endtask

  task automatic send_text(string s, bit start_first = 1'b1);
    for (int i = 0; i < s.len(); i++) send_char(s[i], start_first && i == 0);
  endtask

  // Output side: a check of every taken word, and random stall bursts.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        evt_t exp_e;
        events_seen++;
        if (expected_events.size() == 0) begin
          $error("event with nothing expected: kind %0d", out_event_kind);
          errors++;
        end else begin
          exp_e = expected_events.pop_front();
          if (out_event_kind !== exp_e.event_kind) begin
            $error("event_kind exp %0d got %0d", exp_e.event_kind, out_event_kind);
            errors++;
          end
          if (out_frequency_hz !== exp_e.frequency_hz) begin
            $error("frequency_hz exp %0d got %0d", exp_e.frequency_hz, out_frequency_hz);
            errors++;
          end
          if (out_duration_ms !== exp_e.duration_ms) begin
            $error("duration_ms exp %0d got %0d", exp_e.duration_ms, out_duration_ms);
            errors++;
          end
          if (out_volume_level !== exp_e.volume_level) begin
            $error("volume_level exp %0d got %0d", exp_e.volume_level, out_volume_level);
            errors++;
          end
          if (out_last_event !== exp_e.last_event) begin
            $error("last_event exp %0d got %0d", exp_e.last_event, out_last_event);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  task automatic test_directed();
    // Defaults, accidentals, C-flat wrap, dots, clamps and articulation.
    send_text("C4D+E-.F#..G8...A16B,");
    send_text("o0c-l1t32v0p1rMLn96.n0mS o7b+Ln200t999v200a64,");
    send_text("l64t255e1023 o9c2x<<<<<<<<>>>>>>>>>mq mn");
    send_char(8'h00);
    send_char("a");
    send_text("G", 1'b1);
    send_char("o");
    send_char(8'hff);
    send_char(8'h00);
  endtask

  function automatic string random_token();
    string notes, s;
    notes = "abcdefgprABCDEFG";
    case ($urandom_range(0, 9))
      0: s = $sformatf("o%0d", $urandom_range(0, 9));
      1: s = $sformatf("l%0d", $urandom_range(0, 80));
      2: s = $sformatf("t%0d", $urandom_range(0, 300));
      3: s = $sformatf("v%0d", $urandom_range(0, 140));
      4: s = $urandom_range(0, 1) ? "<" : ">";
      5: s = $urandom_range(0, 2) == 0 ? "mn" : ($urandom_range(0, 1) ? "ml" : "ms");
      6: s = $sformatf("n%0d", $urandom_range(0, 120));
      default: begin
        s = "";
        s = {s, string'(notes[$urandom_range(0, notes.len()-1)])};
        case ($urandom_range(0, 3))
          0: s = {s, "+"};
          1: s = {s, "-"};
          2: s = {s, "#"};
          default: ;
        endcase
        repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 5)) s = {s, "."};
        if ($urandom_range(0, 1)) s = {s, $sformatf("%0d", $urandom_range(0, 70))};
      end
    endcase
    return s;
  endfunction

  task automatic test_random_tracks();
    while (words_sent < 330) begin
      string s;
      s = random_token();
      for (int i = 0; i < s.len(); i++) begin
        logic [7:0] c;
        c = s[i];
        // Occasional noise: any byte, or a fresh start in mid track.
        if ($urandom_range(0, 29) == 0) c = 8'($urandom_range(0, 255));
        send_char(c, words_sent == 0 || $urandom_range(0, 59) == 0);
      end
      if ($urandom_range(0, 19) == 0) send_char($urandom_range(0, 1) ? 8'h00 : ",");
    end
  endtask

  task automatic test_no_idling();
    quiet = 1'b1;
    send_text("T200L8O5cdefgab>c<mlc.d16ms e+,");
  endtask

  initial begin
    restore_defaults();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_tracks();
    test_no_idling();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d text words and checked %0d tone, gap and end events.",
             words_sent, events_seen);
    if (errors == 0) begin
      $display("mml_note_sequencer_tb OK");
    end else begin
      $display("mml_note_sequencer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("mml_note_sequencer_tb NOT OK");
    $finish;
  end
endmodule
